[sv/gspp_pkg.sv]
// Package for the grid shortest-path planner: sizes, codes, shared types and state enums.
`timescale 1ns / 1ps
`default_nettype none
package gspp_pkg;

    localparam int GRID_W         = 64;
    localparam int GRID_H         = 64;
    localparam int COORD_W        = 6;
    localparam int CELL_W         = 12;
    localparam int NCELLS         = GRID_W * GRID_H;
    localparam int COST_W         = 8;
    localparam int DIST_W         = 20;
    localparam int KEY_W          = DIST_W + CELL_W;
    localparam int LEN_W          = 13;
    localparam int DIM_W          = 7;
    localparam int HEAP_DEPTH_DEF = 16384;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_SAT = DIST_INF - DIST_W'(1);

    // Request codes.
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_PLAN = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Register indexes.
    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLOCKED    = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0]  map_width;
        logic [DIM_W-1:0]  map_height;
        logic [COST_W-1:0] blocked_threshold;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [CELL_W-1:0] addr;
        logic [COST_W-1:0] data;
    } t_cost_wr;

    typedef struct packed {
        logic              we;
        logic [CELL_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_path_wr;

    typedef struct packed {
        logic             load;
        logic [LEN_W-1:0] count;
    } t_path_ctl;

    typedef struct packed {
        logic             done;
        logic             unreachable;
        logic [LEN_W-1:0] length;
    } t_plan_res;

    typedef struct packed {
        logic             clear;
        logic             push;
        logic             pop;
        logic [KEY_W-1:0] key;
    } t_heap_cmd;

    typedef struct packed {
        logic busy;
        logic empty;
    } t_heap_stat;

    typedef enum logic [1:0] {
        T_IDLE,
        T_PLAN,
        T_READ
    } t_top_state;

    typedef enum logic [2:0] {
        H_IDLE,
        H_PUSH_STEP,
        H_PUSH_CMP,
        H_POP_LD,
        H_POP_STEP,
        H_POP_CMP
    } t_heap_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SEED,
        S_POP,
        S_POP_WAIT,
        S_CHECK,
        S_NBR,
        S_RELAX,
        S_TRACE,
        S_TRACE_RD,
        S_DONE
    } t_srch_state;

endpackage
`default_nettype wire

[sv/gspp_heap.sv]
// Binary min-heap frontier in a synchronous memory, sifted one level at a time.
`timescale 1ns / 1ps
`default_nettype none
module gspp_heap #(
    parameter int HEAP_DEPTH = gspp_pkg::HEAP_DEPTH_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  gspp_pkg::t_heap_cmd        i_cmd,
    output gspp_pkg::t_heap_stat       o_stat,
    output logic [gspp_pkg::KEY_W-1:0] o_top
);
    import gspp_pkg::*;

    localparam int IW = $clog2(HEAP_DEPTH);
    localparam int CW = IW + 1;

    logic [KEY_W-1:0] r_mem [HEAP_DEPTH];
    logic [KEY_W-1:0] r_rd0, r_rd1;

    t_heap_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [IW-1:0]    r_i, n_i;
    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_top, n_top;

    logic             re, we;
    logic [IW-1:0]    raddr0, raddr1, waddr;
    logic [KEY_W-1:0] wdata;

    logic [CW:0]      child_l, child_r;
    logic [IW-1:0]    parent;
    logic             pick_r;

    assign child_l = {1'b0, r_i, 1'b1};
    assign child_r = child_l + (CW+1)'(1);
    assign parent  = (r_i - IW'(1)) >> 1;
    assign pick_r  = (child_r < {1'b0, r_cnt}) && (r_rd1 < r_rd0);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd0 <= r_mem[raddr0];
            r_rd1 <= r_mem[raddr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_i   <= n_i;
        r_key <= n_key;
        r_top <= n_top;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_key   = r_key;
        n_top   = r_top;
        re      = 1'b0;
        we      = 1'b0;
        raddr0  = '0;
        raddr1  = '0;
        waddr   = '0;
        wdata   = '0;
        unique case (r_state)
            H_IDLE: begin
                if (i_cmd.clear) begin
                    n_cnt = '0;
                end else if (i_cmd.push) begin
                    // A push into a full frontier is dropped.
                    if (r_cnt < CW'(HEAP_DEPTH)) begin
                        n_i     = r_cnt[IW-1:0];
                        n_key   = i_cmd.key;
                        n_cnt   = r_cnt + CW'(1);
                        n_state = H_PUSH_STEP;
                    end
                end else if (i_cmd.pop) begin
                    re      = 1'b1;
                    raddr0  = '0;
                    raddr1  = IW'(r_cnt - CW'(1));
                    n_cnt   = r_cnt - CW'(1);
                    n_state = H_POP_LD;
                end
            end
            H_PUSH_STEP: begin
                if (r_i == '0) begin
                    we      = 1'b1;
                    waddr   = '0;
                    wdata   = r_key;
                    n_state = H_IDLE;
                end else begin
                    re      = 1'b1;
                    raddr0  = parent;
                    raddr1  = parent;
                    n_state = H_PUSH_CMP;
                end
            end
            H_PUSH_CMP: begin
                we    = 1'b1;
                waddr = r_i;
                if (r_rd0 <= r_key) begin
                    wdata   = r_key;
                    n_state = H_IDLE;
                end else begin
                    wdata   = r_rd0;
                    n_i     = parent;
                    n_state = H_PUSH_STEP;
                end
            end
            H_POP_LD: begin
                n_top   = r_rd0;
                n_key   = r_rd1;
                n_i     = '0;
                n_state = H_POP_STEP;
            end
            H_POP_STEP: begin
                if (child_l >= {1'b0, r_cnt}) begin
                    if (r_cnt != '0) begin
                        we    = 1'b1;
                        waddr = r_i;
                        wdata = r_key;
                    end
                    n_state = H_IDLE;
                end else begin
                    re      = 1'b1;
                    raddr0  = child_l[IW-1:0];
                    raddr1  = child_r[IW-1:0];
                    n_state = H_POP_CMP;
                end
            end
            H_POP_CMP: begin
                we    = 1'b1;
                waddr = r_i;
                if (r_key <= (pick_r ? r_rd1 : r_rd0)) begin
                    wdata   = r_key;
                    n_state = H_IDLE;
                end else begin
                    wdata   = pick_r ? r_rd1 : r_rd0;
                    n_i     = pick_r ? child_r[IW-1:0] : child_l[IW-1:0];
                    n_state = H_POP_STEP;
                end
            end
        endcase
    end

    assign o_stat.busy  = (r_state != H_IDLE);
    assign o_stat.empty = (r_cnt == '0);
    assign o_top        = r_top;

endmodule
`default_nettype wire

[sv/gspp_search.sv]
// Cost and node memories with the search sequencer: clear, settle, relax, trace back.
`timescale 1ns / 1ps
`default_nettype none
module gspp_search #(
    parameter int HEAP_DEPTH = gspp_pkg::HEAP_DEPTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  gspp_pkg::t_cfg               i_cfg,
    input  gspp_pkg::t_cost_wr           i_cost_wr,
    input  wire                          i_start,
    input  wire [gspp_pkg::COORD_W-1:0]  i_start_x,
    input  wire [gspp_pkg::COORD_W-1:0]  i_start_y,
    input  wire [gspp_pkg::COORD_W-1:0]  i_goal_x,
    input  wire [gspp_pkg::COORD_W-1:0]  i_goal_y,
    input  wire                          i_ack,
    output gspp_pkg::t_plan_res          o_res,
    output gspp_pkg::t_path_wr           o_path_wr
);
    import gspp_pkg::*;

    typedef struct packed {
        logic              settled;
        logic [1:0]        came;
        logic [DIST_W-1:0] distance;
    } t_node;

    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;
    localparam logic [COORD_W-1:0] EDGE_X = COORD_W'(GRID_W - 1);
    localparam logic [COORD_W-1:0] EDGE_Y = COORD_W'(GRID_H - 1);

    // Undo one move: the cell a step came from, or the cell itself off the grid.
    function automatic logic [CELL_W-1:0] back_step(input logic [CELL_W-1:0] idx,
                                                    input logic [1:0] dir);
        logic [COORD_W-1:0] x, y;
        logic [CELL_W-1:0]  res;
        x   = idx[COORD_W-1:0];
        y   = idx[CELL_W-1:COORD_W];
        res = idx;
        unique case (dir)
            DIR_LEFT:  if (x != EDGE_X) res = {y, x + COORD_W'(1)};
            DIR_RIGHT: if (x != '0)     res = {y, x - COORD_W'(1)};
            DIR_UP:    if (y != EDGE_Y) res = {y + COORD_W'(1), x};
            DIR_DOWN:  if (y != '0)     res = {y - COORD_W'(1), x};
        endcase
        return res;
    endfunction

    logic [COST_W-1:0] r_cost_mem [NCELLS];
    t_node             r_node_mem [NCELLS];
    logic [COST_W-1:0] r_cost_rd;
    t_node             r_node_rd;

    t_srch_state       r_state, n_state;
    logic [CELL_W-1:0] r_s, n_s, r_g, n_g;
    logic [CELL_W-1:0] r_clr, n_clr;
    logic [CELL_W-1:0] r_idx, n_idx;
    logic [DIST_W-1:0] r_d, n_d;
    logic [1:0]        r_dir, n_dir;
    logic [CELL_W-1:0] r_n, n_n;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_unreach, n_unreach;

    logic              node_we, node_re, cost_re;
    logic [CELL_W-1:0] node_waddr, node_raddr;
    t_node             node_wdata;

    t_heap_cmd         heap_cmd;
    t_heap_stat        heap_stat;
    logic [KEY_W-1:0]  heap_top;

    logic [DIM_W-1:0]   w, h;
    logic [COORD_W-1:0] cx, cy;
    logic               nb_ok;
    logic [CELL_W-1:0]  nb;
    logic [DIST_W:0]    sum;
    logic [DIST_W-1:0]  nd;

    gspp_heap #(
        .HEAP_DEPTH(HEAP_DEPTH)
    ) u_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (heap_cmd),
        .o_stat  (heap_stat),
        .o_top   (heap_top)
    );

    // A width or height of zero acts as one, and anything above the grid as the grid.
    always_comb begin
        if (i_cfg.map_width == '0) begin
            w = DIM_W'(1);
        end else if (i_cfg.map_width > DIM_W'(GRID_W)) begin
            w = DIM_W'(GRID_W);
        end else begin
            w = i_cfg.map_width;
        end
        if (i_cfg.map_height == '0) begin
            h = DIM_W'(1);
        end else if (i_cfg.map_height > DIM_W'(GRID_H)) begin
            h = DIM_W'(GRID_H);
        end else begin
            h = i_cfg.map_height;
        end
    end

    assign cx = r_idx[COORD_W-1:0];
    assign cy = r_idx[CELL_W-1:COORD_W];

    always_comb begin
        nb_ok = 1'b0;
        nb    = r_idx;
        unique case (r_dir)
            DIR_LEFT: begin
                nb_ok = (cx != '0);
                nb    = {cy, cx - COORD_W'(1)};
            end
            DIR_RIGHT: begin
                nb_ok = (({1'b0, cx} + DIM_W'(1)) < w);
                nb    = {cy, cx + COORD_W'(1)};
            end
            DIR_UP: begin
                nb_ok = (cy != '0);
                nb    = {cy - COORD_W'(1), cx};
            end
            DIR_DOWN: begin
                nb_ok = (({1'b0, cy} + DIM_W'(1)) < h);
                nb    = {cy + COORD_W'(1), cx};
            end
        endcase
    end

    assign sum = {1'b0, r_d} + (DIST_W+1)'(1) + (DIST_W+1)'(r_cost_rd);
    assign nd  = (sum > {1'b0, DIST_SAT}) ? DIST_SAT : sum[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cost_wr.we) begin
            r_cost_mem[i_cost_wr.addr] <= i_cost_wr.data;
        end
        if (cost_re) begin
            r_cost_rd <= r_cost_mem[node_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_waddr] <= node_wdata;
        end
        if (node_re) begin
            r_node_rd <= r_node_mem[node_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_s       <= n_s;
        r_g       <= n_g;
        r_clr     <= n_clr;
        r_idx     <= n_idx;
        r_d       <= n_d;
        r_dir     <= n_dir;
        r_n       <= n_n;
        r_len     <= n_len;
        r_unreach <= n_unreach;
    end

    always_comb begin
        n_state    = r_state;
        n_s        = r_s;
        n_g        = r_g;
        n_clr      = r_clr;
        n_idx      = r_idx;
        n_d        = r_d;
        n_dir      = r_dir;
        n_n        = r_n;
        n_len      = r_len;
        n_unreach  = r_unreach;
        node_we    = 1'b0;
        node_waddr = '0;
        node_wdata = '0;
        node_re    = 1'b0;
        cost_re    = 1'b0;
        node_raddr = '0;
        heap_cmd   = '0;
        o_path_wr  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_s   = {i_start_y, i_start_x};
                    n_g   = {i_goal_y, i_goal_x};
                    n_len = '0;
                    if (({1'b0, i_start_x} >= w) || ({1'b0, i_start_y} >= h) ||
                        ({1'b0, i_goal_x} >= w) || ({1'b0, i_goal_y} >= h)) begin
                        n_unreach = 1'b1;
                        n_state   = S_DONE;
                    end else if ({i_start_y, i_start_x} == {i_goal_y, i_goal_x}) begin
                        n_unreach = 1'b0;
                        n_state   = S_DONE;
                    end else begin
                        heap_cmd.clear = 1'b1;
                        n_clr          = '0;
                        n_state        = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                // One entry per cycle; the start cell gets distance zero on the way.
                node_we    = 1'b1;
                node_waddr = r_clr;
                node_wdata = '{settled: 1'b0, came: 2'd0,
                               distance: (r_clr == r_s) ? '0 : DIST_INF};
                n_clr      = r_clr + CELL_W'(1);
                if (r_clr == CELL_W'(NCELLS - 1)) begin
                    n_state = S_SEED;
                end
            end
            S_SEED: begin
                heap_cmd.push = 1'b1;
                heap_cmd.key  = {{DIST_W{1'b0}}, r_s};
                n_state       = S_POP;
            end
            S_POP: begin
                if (!heap_stat.busy) begin
                    if (heap_stat.empty) begin
                        n_unreach = 1'b1;
                        n_len     = '0;
                        n_state   = S_DONE;
                    end else begin
                        heap_cmd.pop = 1'b1;
                        n_state      = S_POP_WAIT;
                    end
                end
            end
            S_POP_WAIT: begin
                if (!heap_stat.busy) begin
                    n_idx      = heap_top[CELL_W-1:0];
                    n_d        = heap_top[KEY_W-1:CELL_W];
                    node_re    = 1'b1;
                    node_raddr = heap_top[CELL_W-1:0];
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                // Stale frontier entries and settled cells are dropped here.
                if (r_node_rd.settled || (r_d > r_node_rd.distance)) begin
                    n_state = S_POP;
                end else begin
                    node_we    = 1'b1;
                    node_waddr = r_idx;
                    node_wdata = '{settled: 1'b1, came: r_node_rd.came,
                                   distance: r_node_rd.distance};
                    if (r_idx == r_g) begin
                        n_len   = '0;
                        n_n     = r_g;
                        n_state = S_TRACE;
                    end else begin
                        n_dir   = DIR_LEFT;
                        n_state = S_NBR;
                    end
                end
            end
            S_NBR: begin
                if (!heap_stat.busy) begin
                    if (nb_ok) begin
                        n_n        = nb;
                        node_re    = 1'b1;
                        cost_re    = 1'b1;
                        node_raddr = nb;
                        n_state    = S_RELAX;
                    end else if (r_dir == DIR_DOWN) begin
                        n_state = S_POP;
                    end else begin
                        n_dir = r_dir + 2'd1;
                    end
                end
            end
            S_RELAX: begin
                if (!r_node_rd.settled && (r_cost_rd < i_cfg.blocked_threshold) &&
                    (nd < r_node_rd.distance)) begin
                    node_we       = 1'b1;
                    node_waddr    = r_n;
                    node_wdata    = '{settled: 1'b0, came: r_dir, distance: nd};
                    heap_cmd.push = 1'b1;
                    heap_cmd.key  = {nd, r_n};
                end
                if (r_dir == DIR_DOWN) begin
                    n_state = S_POP;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = S_NBR;
                end
            end
            S_TRACE: begin
                // The path is stored goal first; the read side reverses the order.
                if ((r_n == r_s) || (r_len == LEN_W'(NCELLS))) begin
                    n_unreach = 1'b0;
                    n_state   = S_DONE;
                end else begin
                    o_path_wr.we   = 1'b1;
                    o_path_wr.addr = r_len[CELL_W-1:0];
                    o_path_wr.data = r_n;
                    node_re        = 1'b1;
                    node_raddr     = r_n;
                    n_state        = S_TRACE_RD;
                end
            end
            S_TRACE_RD: begin
                n_n     = back_step(r_n, r_node_rd.came);
                n_len   = r_len + LEN_W'(1);
                n_state = S_TRACE;
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    assign o_res.done        = (r_state == S_DONE);
    assign o_res.unreachable = r_unreach;
    assign o_res.length      = r_len;

endmodule
`default_nettype wire

[sv/gspp_path.sv]
// Path step memory with the step count and read pointer.
`timescale 1ns / 1ps
`default_nettype none
module gspp_path (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  gspp_pkg::t_path_wr           i_wr,
    input  gspp_pkg::t_path_ctl          i_ctl,
    input  wire                          i_rd,
    output logic [gspp_pkg::COORD_W-1:0] o_step_x,
    output logic [gspp_pkg::COORD_W-1:0] o_step_y,
    output logic                         o_last,
    output logic                         o_step_valid
);
    import gspp_pkg::*;

    logic [CELL_W-1:0] r_mem [NCELLS];
    logic [CELL_W-1:0] r_rd;
    logic [LEN_W-1:0]  r_count, r_ptr;
    logic              r_valid, r_last;

    logic              hit;
    logic [LEN_W-1:0]  raddr;

    assign hit   = (r_ptr < r_count);
    assign raddr = r_count - LEN_W'(1) - r_ptr;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd && hit) begin
            r_rd <= r_mem[raddr[CELL_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else if (i_ctl.load) begin
            r_count <= i_ctl.count;
            r_ptr   <= '0;
        end else if (i_rd) begin
            r_valid <= hit;
            r_last  <= hit && ((r_ptr + LEN_W'(1)) == r_count);
            if (hit) begin
                r_ptr <= r_ptr + LEN_W'(1);
            end
        end
    end

    assign o_step_x     = r_valid ? r_rd[COORD_W-1:0] : '0;
    assign o_step_y     = r_valid ? r_rd[CELL_W-1:COORD_W] : '0;
    assign o_last       = r_last;
    assign o_step_valid = r_valid;

endmodule
`default_nettype wire

[sv/grid_shortest_path_planner_top.sv]
// Top level of the grid shortest-path planner: register port, request control, result register.
//
//   Channel   Direction  Handshake                    Carries
//   request   in         i_in_valid / o_in_stall      req_type, cell, cost, start, goal
//   result    out        o_out_valid / i_out_stall    path_length, unreachable, step fields
//   config    in         APB psel/penable/pwrite      map_width, map_height, blocked_threshold
//
// A load word writes the cost memory from the idle state; a read word is read from the path
// memory and registered through the read state. A plan runs a clearing pass over all 4096 node
// entries, then the search, where each heap push or pop sifts the frontier memory level by
// level, then a trace back over the path steps.
// Reset is synchronous and active low; it leaves no path and empty frontier.
// A stalled result stays in the output register; the next word is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module grid_shortest_path_planner_top #(
    parameter int HEAP_DEPTH = gspp_pkg::HEAP_DEPTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire  [1:0]                     i_req_type,
    input  wire  [gspp_pkg::COORD_W-1:0]   i_cell_x,
    input  wire  [gspp_pkg::COORD_W-1:0]   i_cell_y,
    input  wire  [gspp_pkg::COST_W-1:0]    i_cell_cost,
    input  wire  [gspp_pkg::COORD_W-1:0]   i_start_x,
    input  wire  [gspp_pkg::COORD_W-1:0]   i_start_y,
    input  wire  [gspp_pkg::COORD_W-1:0]   i_goal_x,
    input  wire  [gspp_pkg::COORD_W-1:0]   i_goal_y,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [gspp_pkg::LEN_W-1:0]     o_path_length,
    output logic                           o_unreachable,
    output logic [gspp_pkg::COORD_W-1:0]   o_step_x,
    output logic [gspp_pkg::COORD_W-1:0]   o_step_y,
    output logic                           o_last,
    output logic                           o_step_valid,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [gspp_pkg::ADDR_W-1:0]    paddr,
    input  wire  [gspp_pkg::DATA_W-1:0]    pwdata,
    output logic [gspp_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import gspp_pkg::*;

    t_cfg       r_cfg;
    t_top_state r_state, n_state;

    logic               r_out_valid, n_out_valid;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_unreach, n_unreach;
    logic [COORD_W-1:0] r_sx, n_sx, r_sy, n_sy;
    logic               r_last, n_last, r_sv, n_sv;

    logic       accept, out_free, cfg_wr;
    logic       start, ack, rd;
    t_cost_wr   cost_wr;
    t_path_wr   path_wr;
    t_path_ctl  path_ctl;
    t_plan_res  res;

    logic [COORD_W-1:0] p_x, p_y;
    logic               p_last, p_valid;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_width         <= DIM_W'(GRID_W);
            r_cfg.map_height        <= DIM_W'(GRID_H);
            r_cfg.blocked_threshold <= COST_W'(99);
        end else if (cfg_wr) begin
            case (paddr[ADDR_W-1:2])
                REG_MAP_WIDTH:  r_cfg.map_width         <= pwdata[DIM_W-1:0];
                REG_MAP_HEIGHT: r_cfg.map_height        <= pwdata[DIM_W-1:0];
                REG_BLOCKED:    r_cfg.blocked_threshold <= pwdata[COST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_MAP_WIDTH:  prdata = DATA_W'(r_cfg.map_width);
            REG_MAP_HEIGHT: prdata = DATA_W'(r_cfg.map_height);
            REG_BLOCKED:    prdata = DATA_W'(r_cfg.blocked_threshold);
            default:        prdata = '0;
        endcase
    end

    gspp_search #(
        .HEAP_DEPTH(HEAP_DEPTH)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cost_wr (cost_wr),
        .i_start   (start),
        .i_start_x (i_start_x),
        .i_start_y (i_start_y),
        .i_goal_x  (i_goal_x),
        .i_goal_y  (i_goal_y),
        .i_ack     (ack),
        .o_res     (res),
        .o_path_wr (path_wr)
    );

    gspp_path u_path (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (path_wr),
        .i_ctl        (path_ctl),
        .i_rd         (rd),
        .o_step_x     (p_x),
        .o_step_y     (p_y),
        .o_last       (p_last),
        .o_step_valid (p_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_len     <= n_len;
        r_unreach <= n_unreach;
        r_sx      <= n_sx;
        r_sy      <= n_sy;
        r_last    <= n_last;
        r_sv      <= n_sv;
    end

    always_comb begin
        n_state        = r_state;
        n_out_valid    = r_out_valid && i_out_stall;
        n_len          = r_len;
        n_unreach      = r_unreach;
        n_sx           = r_sx;
        n_sy           = r_sy;
        n_last         = r_last;
        n_sv           = r_sv;
        o_in_stall     = (r_state != T_IDLE);
        start          = 1'b0;
        ack            = 1'b0;
        rd             = 1'b0;
        cost_wr.we     = 1'b0;
        cost_wr.addr   = {i_cell_y, i_cell_x};
        cost_wr.data   = i_cell_cost;
        path_ctl.load  = 1'b0;
        path_ctl.count = '0;
        unique case (r_state)
            T_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_LOAD: cost_wr.we = 1'b1;
                        REQ_PLAN: begin
                            start         = 1'b1;
                            path_ctl.load = 1'b1;
                            n_state       = T_PLAN;
                        end
                        REQ_READ: begin
                            rd      = 1'b1;
                            n_state = T_READ;
                        end
                        default: ;
                    endcase
                end
            end
            T_PLAN: begin
                if (res.done && out_free) begin
                    ack            = 1'b1;
                    path_ctl.load  = 1'b1;
                    path_ctl.count = res.length;
                    n_out_valid    = 1'b1;
                    n_len          = res.length;
                    n_unreach      = res.unreachable;
                    n_sx           = '0;
                    n_sy           = '0;
                    n_last         = 1'b0;
                    n_sv           = 1'b0;
                    n_state        = T_IDLE;
                end
            end
            T_READ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_len       = '0;
                    n_unreach   = 1'b0;
                    n_sx        = p_x;
                    n_sy        = p_y;
                    n_last      = p_last;
                    n_sv        = p_valid;
                    n_state     = T_IDLE;
                end
            end
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_path_length = r_len;
    assign o_unreachable = r_unreach;
    assign o_step_x      = r_sx;
    assign o_step_y      = r_sy;
    assign o_last        = r_last;
    assign o_step_valid  = r_sv;

endmodule
`default_nettype wire
